[rtl/core/crps_pkg.sv]
package crps_pkg;

  localparam int unsigned CoordW     = 13;
  localparam int unsigned OffsetW    = 11;
  localparam int unsigned ColorW     = 32;
  localparam int unsigned PixelW     = 12;
  localparam int unsigned SizeW      = 8;
  localparam int unsigned PercentW   = 7;
  localparam int unsigned CanvasW    = 13;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 13;

  localparam logic [SizeW-1:0]    NibSizeReset   = 8'd14;
  localparam logic [PercentW-1:0] AspectReset    = 7'd20;
  localparam logic [PercentW-1:0] StrengthReset  = 7'd100;
  localparam logic [CanvasW-1:0]  CanvasReset    = 13'd1024;
  localparam logic [CanvasW-1:0]  CanvasMax      = 13'd4096;
  localparam logic [PercentW-1:0] PercentMax     = 7'd100;

  localparam logic [15:0] LumWeightR = 16'd77;
  localparam logic [15:0] LumWeightG = 16'd150;
  localparam logic [15:0] LumWeightB = 16'd29;
  localparam logic [14:0] FullScale  = 15'd255;

  // floor(p / 100) for p below 43699 is (p * 5243) >> 19.
  localparam logic [27:0] Div100Mul   = 28'd5243;
  localparam int unsigned Div100Shift = 19;
  // floor(v / 25500) for v below 2**23 is (v * 5389763) >> 37.
  localparam logic [45:0] Div25500Mul   = 46'd5389763;
  localparam int unsigned Div25500Shift = 37;

  typedef enum logic [CfgIdxW-1:0] {
    CfgNibSize        = 3'd0,
    CfgAspectPercent  = 3'd1,
    CfgTextureMode    = 3'd2,
    CfgTextureStrength= 3'd3,
    CfgCanvasWidth    = 3'd4,
    CfgCanvasHeight   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TexOff      = 2'd0,
    TexLumAlpha = 2'd1,
    TexRgbMul   = 2'd2,
    TexNone     = 2'd3
  } tex_mode_e;

endpackage

[rtl/core/crps_in_if.sv]
interface crps_in_if;
  import crps_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [CoordW-1:0]   center_x;
  logic signed [CoordW-1:0]   center_y;
  logic signed [OffsetW-1:0]  offset_x;
  logic signed [OffsetW-1:0]  offset_y;
  logic [ColorW-1:0]          brush_color;
  logic [ColorW-1:0]          texture_color;
  logic                       texture_present;
  logic                       eraser;

  modport source (
    output valid, center_x, center_y, offset_x, offset_y, brush_color, texture_color,
           texture_present, eraser,
    input  ready
  );

  modport sink (
    input  valid, center_x, center_y, offset_x, offset_y, brush_color, texture_color,
           texture_present, eraser,
    output ready
  );
endinterface

[rtl/core/crps_out_if.sv]
interface crps_out_if;
  import crps_pkg::*;

  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [PixelW-1:0]  pixel_x;
  logic [PixelW-1:0]  pixel_y;
  logic [ColorW-1:0]  pixel_color;

  modport source (
    output valid, write_enable, pixel_x, pixel_y, pixel_color,
    input  ready
  );

  modport sink (
    input  valid, write_enable, pixel_x, pixel_y, pixel_color,
    output ready
  );
endinterface

[rtl/core/chisel_ribbon_pixel_shader.sv]
// Shades one candidate pixel of a 45-degree chisel brush stamp per clock: the pixel is clipped
// to the canvas, tested against the stamp square and the chisel ribbon, and given the brush
// color, zero for the eraser, or the color modulated by the texture sample. The datapath is a
// four-stage pipeline (geometry and texture products, clip and blend terms, alpha product,
// reciprocal divide into the output register), and a new pixel is taken every cycle while
// the output is drained. Each stage holds its item independently, so a stalled output still
// lets bubbles fill. Configuration writes are taken at any cycle but must only be issued while
// no pixel is in flight; the ribbon thickness derived from the nib size and aspect passes
// through thick_prod_q and then thick2_q after such a write.
module chisel_ribbon_pixel_shader (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crps_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [crps_pkg::CfgDataW-1:0] cfg_data_i,
  crps_in_if.sink                       px_in_i,
  crps_out_if.source                    px_out_o
);
  import crps_pkg::*;

  logic [SizeW-1:0]    nib_size_q;
  logic [PercentW-1:0] aspect_q;
  tex_mode_e           tex_mode_q;
  logic [PercentW-1:0] strength_q;
  logic [CanvasW-1:0]  canvas_w_q;
  logic [CanvasW-1:0]  canvas_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nib_size_q <= NibSizeReset;
      aspect_q   <= AspectReset;
      tex_mode_q <= TexLumAlpha;
      strength_q <= StrengthReset;
      canvas_w_q <= CanvasReset;
      canvas_h_q <= CanvasReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgNibSize:         nib_size_q <= cfg_data_i[SizeW-1:0];
        CfgAspectPercent:   aspect_q   <= cfg_data_i[PercentW-1:0];
        CfgTextureMode:     tex_mode_q <= tex_mode_e'(cfg_data_i[1:0]);
        CfgTextureStrength: strength_q <= cfg_data_i[PercentW-1:0];
        CfgCanvasWidth:     canvas_w_q <= cfg_data_i[CanvasW-1:0];
        CfgCanvasHeight:    canvas_h_q <= cfg_data_i[CanvasW-1:0];
        default: begin
        end
      endcase
    end
  end

  logic [SizeW-1:0]    size_eff;
  logic [PercentW-1:0] aspect_eff;
  logic [PercentW-1:0] strength_eff;
  logic [CanvasW-1:0]  canvas_w_eff;
  logic [CanvasW-1:0]  canvas_h_eff;
  logic [9:0]          radius;

  assign size_eff     = (nib_size_q == '0) ? SizeW'(1) : nib_size_q;
  assign aspect_eff   = (aspect_q > PercentMax) ? PercentMax : aspect_q;
  assign strength_eff = (strength_q > PercentMax) ? PercentMax : strength_q;
  assign canvas_w_eff = (canvas_w_q > CanvasMax) ? CanvasMax : canvas_w_q;
  assign canvas_h_eff = (canvas_h_q > CanvasMax) ? CanvasMax : canvas_h_q;
  assign radius       = 10'({size_eff, 1'b0}) + 10'd2;

  // Ribbon half width, twice the thickness, kept in step with the settings.
  logic [14:0] thick_prod_q;
  logic [9:0]  thick2_q;
  logic [27:0] thick_quot;
  logic [8:0]  thick;

  assign thick_quot = (28'(thick_prod_q) * Div100Mul) >> Div100Shift;
  assign thick      = 9'(thick_quot) + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thick_prod_q <= 15'(NibSizeReset) * 15'(AspectReset);
      thick2_q     <= 10'd6;
    end else begin
      thick_prod_q <= 15'(size_eff) * 15'(aspect_eff);
      thick2_q     <= {thick, 1'b0};
    end
  end

  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic s1_en, s2_en, s3_en, out_en;

  assign out_en        = !out_v_q || px_out_o.ready;
  assign s3_en         = !s3_v_q || out_en;
  assign s2_en         = !s2_v_q || s3_en;
  assign s1_en         = !s1_v_q || s2_en;
  assign px_in_i.ready = s1_en;

  // Stage 1: positions, offset magnitudes, luminance and channel products.
  logic signed [13:0] px_d, py_d;
  logic signed [11:0] sum_d, diff_d;
  logic [10:0]        adx_d, ady_d;
  logic [11:0]        asum_d, adiff_d;
  logic [15:0]        lum_sum;
  logic [7:0]         tex_r, tex_g, tex_b;

  assign tex_r  = px_in_i.texture_color[7:0];
  assign tex_g  = px_in_i.texture_color[15:8];
  assign tex_b  = px_in_i.texture_color[23:16];
  assign px_d   = 14'(px_in_i.center_x) + 14'(px_in_i.offset_x);
  assign py_d   = 14'(px_in_i.center_y) + 14'(px_in_i.offset_y);
  assign sum_d  = 12'(px_in_i.offset_x) + 12'(px_in_i.offset_y);
  assign diff_d = 12'(px_in_i.offset_y) - 12'(px_in_i.offset_x);
  assign adx_d  = px_in_i.offset_x[10] ? 11'(-px_in_i.offset_x) : 11'(px_in_i.offset_x);
  assign ady_d  = px_in_i.offset_y[10] ? 11'(-px_in_i.offset_y) : 11'(px_in_i.offset_y);
  assign asum_d  = sum_d[11] ? 12'(-sum_d) : 12'(sum_d);
  assign adiff_d = diff_d[11] ? 12'(-diff_d) : 12'(diff_d);
  assign lum_sum = 16'(tex_r) * LumWeightR + 16'(tex_g) * LumWeightG + 16'(tex_b) * LumWeightB;

  logic signed [13:0] s1_px_q, s1_py_q;
  logic [10:0]        s1_adx_q, s1_ady_q;
  logic [11:0]        s1_asum_q, s1_adiff_q;
  logic [ColorW-1:0]  s1_color_q;
  logic [7:0]         s1_lum_q;
  logic [15:0]        s1_pr_q, s1_pg_q, s1_pb_q;
  logic               s1_present_q, s1_erase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= px_in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && px_in_i.valid) begin
      s1_px_q      <= px_d;
      s1_py_q      <= py_d;
      s1_adx_q     <= adx_d;
      s1_ady_q     <= ady_d;
      s1_asum_q    <= asum_d;
      s1_adiff_q   <= adiff_d;
      s1_color_q   <= px_in_i.brush_color;
      s1_lum_q     <= lum_sum[15:8];
      s1_pr_q      <= 16'(px_in_i.brush_color[7:0]) * 16'(tex_r);
      s1_pg_q      <= 16'(px_in_i.brush_color[15:8]) * 16'(tex_g);
      s1_pb_q      <= 16'(px_in_i.brush_color[23:16]) * 16'(tex_b);
      s1_present_q <= px_in_i.texture_present;
      s1_erase_q   <= px_in_i.eraser;
    end
  end

  // Stage 2: canvas clip, stamp square, alpha blend term, channel divide by 255.
  logic        clip_ok, square_ok;
  logic [14:0] blend_d;
  logic [16:0] qr_sum, qg_sum, qb_sum;

  assign clip_ok = !s1_px_q[13] && (s1_px_q[12:0] < canvas_w_eff) &&
                   !s1_py_q[13] && (s1_py_q[12:0] < canvas_h_eff);
  assign square_ok = (s1_adx_q <= 11'(radius)) && (s1_ady_q <= 11'(radius)) &&
                     (s1_asum_q <= 12'(radius));
  assign blend_d = 15'(s1_lum_q) * 15'(strength_eff) +
                   FullScale * 15'(PercentMax - strength_eff);
  assign qr_sum = 17'(s1_pr_q) + 17'(s1_pr_q[15:8]) + 17'd1;
  assign qg_sum = 17'(s1_pg_q) + 17'(s1_pg_q[15:8]) + 17'd1;
  assign qb_sum = 17'(s1_pb_q) + 17'(s1_pb_q[15:8]) + 17'd1;

  logic              s2_we_q;
  logic [11:0]       s2_adiff_q;
  logic [PixelW-1:0] s2_x_q, s2_y_q;
  logic [ColorW-1:0] s2_color_q;
  logic [14:0]       s2_blend_q;
  logic [7:0]        s2_qr_q, s2_qg_q, s2_qb_q;
  logic              s2_present_q, s2_erase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      s2_we_q      <= clip_ok && square_ok;
      s2_adiff_q   <= s1_adiff_q;
      s2_x_q       <= s1_px_q[PixelW-1:0];
      s2_y_q       <= s1_py_q[PixelW-1:0];
      s2_color_q   <= s1_color_q;
      s2_blend_q   <= blend_d;
      s2_qr_q      <= qr_sum[15:8];
      s2_qg_q      <= qg_sum[15:8];
      s2_qb_q      <= qb_sum[15:8];
      s2_present_q <= s1_present_q;
      s2_erase_q   <= s1_erase_q;
    end
  end

  // Stage 3: ribbon thickness test and alpha product.
  logic              s3_we_q;
  logic [PixelW-1:0] s3_x_q, s3_y_q;
  logic [ColorW-1:0] s3_color_q;
  logic [22:0]       s3_aprod_q;
  logic [7:0]        s3_qr_q, s3_qg_q, s3_qb_q;
  logic              s3_present_q, s3_erase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (s3_en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_v_q) begin
      s3_we_q      <= s2_we_q && (s2_adiff_q <= 12'(thick2_q));
      s3_x_q       <= s2_x_q;
      s3_y_q       <= s2_y_q;
      s3_color_q   <= s2_color_q;
      s3_aprod_q   <= 23'(s2_color_q[31:24]) * 23'(s2_blend_q);
      s3_qr_q      <= s2_qr_q;
      s3_qg_q      <= s2_qg_q;
      s3_qb_q      <= s2_qb_q;
      s3_present_q <= s2_present_q;
      s3_erase_q   <= s2_erase_q;
    end
  end

  // Stage 4: alpha divide by 25500 and color selection into the output register.
  logic [45:0]       alpha_quot;
  logic [ColorW-1:0] shaded;
  logic              tex_bypass;

  assign alpha_quot = (46'(s3_aprod_q) * Div25500Mul) >> Div25500Shift;
  assign tex_bypass = !s3_present_q || (strength_eff == '0);

  always_comb begin
    shaded = s3_color_q;
    if (!tex_bypass) begin
      case (tex_mode_q)
        TexLumAlpha: shaded = {alpha_quot[7:0], s3_color_q[23:0]};
        TexRgbMul:   shaded = {s3_color_q[31:24], s3_qb_q, s3_qg_q, s3_qr_q};
        default:     shaded = s3_color_q;
      endcase
    end
  end

  logic              out_we_q;
  logic [PixelW-1:0] out_x_q, out_y_q;
  logic [ColorW-1:0] out_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s3_v_q) begin
      out_we_q    <= s3_we_q;
      out_x_q     <= s3_we_q ? s3_x_q : '0;
      out_y_q     <= s3_we_q ? s3_y_q : '0;
      out_color_q <= (s3_we_q && !s3_erase_q) ? shaded : '0;
    end
  end

  assign px_out_o.valid        = out_v_q;
  assign px_out_o.write_enable = out_we_q;
  assign px_out_o.pixel_x      = out_x_q;
  assign px_out_o.pixel_y      = out_y_q;
  assign px_out_o.pixel_color  = out_color_q;

endmodule
